FILE: hw/rtl/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types, constants and the sine table builder for the asymmetric
// sine pulse generator.
// ----------------------------------------------------------------------------
package asp_pkg;

  // Phase word and sine table geometry
  localparam int unsigned PHASE_BITS   = 24;
  localparam int unsigned SINE_ENTRIES = 1024;
  localparam int unsigned SINE_ADDR_W  = $clog2(SINE_ENTRIES);

  // Field widths
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned AMP_W    = 24;
  localparam int unsigned SINE_W   = 16;
  localparam int unsigned SAMPLE_W = 25;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W   = PHASE_BITS + GAIN_W;
  localparam int unsigned AMP_PROD_W = AMP_W + SINE_W;

  // Angle offsets: three quarters of a turn while rising, one quarter falling
  localparam logic [PHASE_BITS-1:0] ANGLE_RISE_BASE =
    PHASE_BITS'(3) << (PHASE_BITS - 2);
  localparam logic [PHASE_BITS-1:0] ANGLE_FALL_BASE =
    PHASE_BITS'(1) << (PHASE_BITS - 2);

  localparam logic [AMP_PROD_W:0] AMP_ROUND = (AMP_PROD_W + 1)'(16384);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BREAKPOINT         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_GAIN          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_GAIN          = 3'd6;

  // Register reset values
  localparam logic [CNT_W-1:0]  RST_SAMPLES_PER_PERIOD = 16'd50;
  localparam logic [CNT_W-1:0]  RST_PERIOD_COUNT       = 16'd22;
  localparam logic [CFG_W-1:0]  RST_PHASE_STEP         = 24'd335544;
  localparam logic [AMP_W-1:0]  RST_AMPLITUDE          = 24'd2048;
  localparam logic [CFG_W-1:0]  RST_BREAKPOINT         = 24'd6710886;
  localparam logic [GAIN_W-1:0] RST_RISE_GAIN          = 24'd81920;
  localparam logic [GAIN_W-1:0] RST_FALL_GAIN          = 24'd54613;

  typedef struct packed {
    logic [CNT_W-1:0]  samples_per_period;
    logic [CNT_W-1:0]  period_count;
    logic [CFG_W-1:0]  phase_step;
    logic [AMP_W-1:0]  amplitude;
    logic [CFG_W-1:0]  breakpoint;
    logic [GAIN_W-1:0] rise_gain;
    logic [GAIN_W-1:0] fall_gain;
  } asp_cfg_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic load;  // take the beat, update phase and counters
    logic mul;   // form the angle
    logic rom;   // look up the sine
    logic out;   // scale and load the output register
  } asp_cmd_t;

  typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_ENTRIES];

  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // Q1.15 sine of entry i: Taylor series in Q2.30 on the first quadrant
  function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned i);
    logic [63:0]        u;
    logic [1:0]         quad;
    logic [63:0]        f;
    logic [63:0]        theta;
    logic [63:0]        theta2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        mag;
    u      = (64'(i % SINE_ENTRIES) << 32) / SINE_ENTRIES;
    quad   = u[31:30];
    f      = {34'd0, u[29:0]};
    if (quad[0]) begin
      f = Q30_ONE - f;
    end
    theta  = (f * TWO_PI_Q30) >> 32;
    theta2 = (theta * theta) >> 30;
    term   = theta;
    sum    = $signed(term);
    term   = ((term * theta2) >> 30) / 64'd6;
    sum    = sum - $signed(term);
    term   = ((term * theta2) >> 30) / 64'd20;
    sum    = sum + $signed(term);
    term   = ((term * theta2) >> 30) / 64'd42;
    sum    = sum - $signed(term);
    term   = ((term * theta2) >> 30) / 64'd72;
    sum    = sum + $signed(term);
    term   = ((term * theta2) >> 30) / 64'd110;
    sum    = sum - $signed(term);
    term   = ((term * theta2) >> 30) / 64'd156;
    sum    = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    mag = ($unsigned(sum) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    if (quad[1]) begin
      return -$signed(SINE_W'(mag));
    end
    return $signed(SINE_W'(mag));
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int unsigned i = 0; i < SINE_ENTRIES; i++) begin
      tab[i] = sine_entry(i);
    end
    return tab;
  endfunction

endpackage

FILE: hw/rtl/asp_cfg.sv
// ----------------------------------------------------------------------------
// asp_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module asp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [asp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [asp_pkg::CFG_W-1:0]    cfg_wdata_i,
  output asp_pkg::asp_cfg_t            cfg_o
);
  import asp_pkg::*;

  asp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLES_PER_PERIOD: cfg_d.samples_per_period = cfg_wdata_i[CNT_W-1:0];
        REG_PERIOD_COUNT:       cfg_d.period_count       = cfg_wdata_i[CNT_W-1:0];
        REG_PHASE_STEP:         cfg_d.phase_step         = cfg_wdata_i;
        REG_AMPLITUDE:          cfg_d.amplitude          = cfg_wdata_i;
        REG_BREAKPOINT:         cfg_d.breakpoint         = cfg_wdata_i;
        REG_RISE_GAIN:          cfg_d.rise_gain          = cfg_wdata_i;
        REG_FALL_GAIN:          cfg_d.fall_gain          = cfg_wdata_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples_per_period <= RST_SAMPLES_PER_PERIOD;
      cfg_q.period_count       <= RST_PERIOD_COUNT;
      cfg_q.phase_step         <= RST_PHASE_STEP;
      cfg_q.amplitude          <= RST_AMPLITUDE;
      cfg_q.breakpoint         <= RST_BREAKPOINT;
      cfg_q.rise_gain          <= RST_RISE_GAIN;
      cfg_q.fall_gain          <= RST_FALL_GAIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/asp_ctrl.sv
// ----------------------------------------------------------------------------
// asp_ctrl
// Sequencer: steps one beat through angle, sine lookup and scaling, and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module asp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output asp_pkg::asp_cmd_t cmd_o
);
  import asp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ROM  = 4'b0100,
    S_AMP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   room;

  // Output register is free when empty or being drained this cycle
  assign room = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ROM;
      end
      S_ROM: begin
        cmd_o.rom = 1'b1;
        state_d   = S_AMP;
      end
      S_AMP: begin
        // hold here until the previous result has gone
        if (room) begin
          cmd_o.out = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/asp_sine_rom.sv
// ----------------------------------------------------------------------------
// asp_sine_rom
// Full-wave Q1.15 sine table with a registered read port.
// ----------------------------------------------------------------------------
module asp_sine_rom (
  input  logic                               clk_i,
  input  logic                               rd_en_i,
  input  logic [asp_pkg::SINE_ADDR_W-1:0]    rd_addr_i,
  output logic signed [asp_pkg::SINE_W-1:0]  rd_data_o
);
  import asp_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic signed [SINE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= SINE_TAB[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/asp_datapath.sv
// ----------------------------------------------------------------------------
// asp_datapath
// Phase and counter state, angle multiply, sine lookup and amplitude
// scaling, driven by the sequencer's commands.
// ----------------------------------------------------------------------------
module asp_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  asp_pkg::asp_cmd_t                cmd_i,
  input  asp_pkg::asp_cfg_t                cfg_i,
  input  logic                             restart_i,
  output logic [asp_pkg::SAMPLE_W-1:0]     sample_o,
  output logic                             period_end_o,
  output logic                             last_o
);
  import asp_pkg::*;

  // Running state
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]      smp_idx_q, smp_idx_d;
  logic [CNT_W-1:0]      per_idx_q, per_idx_d;

  // Per-beat working registers
  logic [PHASE_BITS-1:0] opnd_q;
  logic [GAIN_W-1:0]     gain_q;
  logic [PHASE_BITS-1:0] base_q;
  logic [PHASE_BITS-1:0] angle_q;
  logic                  pend_q;
  logic                  last_q;

  // Output register
  logic [SAMPLE_W-1:0]   sample_q;
  logic                  period_end_q;
  logic                  last_out_q;

  logic [PHASE_BITS-1:0] ph;
  logic [CNT_W-1:0]      si;
  logic [CNT_W-1:0]      pi;
  logic [PHASE_BITS-1:0] bp;
  logic [PHASE_BITS-1:0] step;
  logic                  rise;
  logic [CNT_W-1:0]      spp_last;
  logic [CNT_W-1:0]      pc_last;
  logic                  pend;
  logic                  lst;
  logic [PROD_W-1:0]     prod;
  logic signed [SINE_W-1:0] sine;
  logic [SINE_W-1:0]     ofs;
  logic [AMP_PROD_W-1:0] amp_prod;
  logic [AMP_PROD_W:0]   amp_sum;

  // Restart clears phase and counters ahead of this beat
  assign ph   = restart_i ? '0 : phase_q;
  assign si   = restart_i ? '0 : smp_idx_q;
  assign pi   = restart_i ? '0 : per_idx_q;
  assign bp   = cfg_i.breakpoint[PHASE_BITS-1:0];
  assign step = cfg_i.phase_step[PHASE_BITS-1:0];
  assign rise = ph < bp;

  // A zero length acts as one
  assign spp_last = (cfg_i.samples_per_period == '0) ? '0
                  : cfg_i.samples_per_period - CNT_W'(1);
  assign pc_last  = (cfg_i.period_count == '0) ? '0
                  : cfg_i.period_count - CNT_W'(1);
  assign pend     = si >= spp_last;
  assign lst      = pend && (pi >= pc_last);

  always_comb begin
    phase_d   = phase_q;
    smp_idx_d = smp_idx_q;
    per_idx_d = per_idx_q;
    if (cmd_i.load) begin
      if (pend) begin
        phase_d   = '0;
        smp_idx_d = '0;
        per_idx_d = lst ? '0 : pi + CNT_W'(1);
      end else begin
        phase_d   = ph + step;
        smp_idx_d = si + CNT_W'(1);
        per_idx_d = pi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      smp_idx_q <= '0;
      per_idx_q <= '0;
    end else begin
      phase_q   <= phase_d;
      smp_idx_q <= smp_idx_d;
      per_idx_q <= per_idx_d;
    end
  end

  // Pick slope and offset for the half of the period we are in
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opnd_q <= rise ? ph : ph - bp;
      gain_q <= rise ? cfg_i.rise_gain : cfg_i.fall_gain;
      base_q <= rise ? ANGLE_RISE_BASE : ANGLE_FALL_BASE;
      pend_q <= pend;
      last_q <= lst;
    end
  end

  // Angle wraps modulo one turn
  assign prod = PROD_W'(opnd_q) * PROD_W'(gain_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      angle_q <= base_q + prod[16 +: PHASE_BITS];
    end
  end

  asp_sine_rom u_sine_rom (
    .clk_i     (clk_i),
    .rd_en_i   (cmd_i.rom),
    .rd_addr_i (angle_q[PHASE_BITS-1 -: SINE_ADDR_W]),
    .rd_data_o (sine)
  );

  // 32768 + s is the sine with its sign bit flipped
  assign ofs      = {~sine[SINE_W-1], sine[SINE_W-2:0]};
  assign amp_prod = AMP_PROD_W'(cfg_i.amplitude) * AMP_PROD_W'(ofs);
  assign amp_sum  = {1'b0, amp_prod} + AMP_ROUND;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out) begin
      sample_q     <= amp_sum[15 +: SAMPLE_W];
      period_end_q <= pend_q;
      last_out_q   <= last_q;
    end
  end

  assign sample_o     = sample_q;
  assign period_end_o = period_end_q;
  assign last_o       = last_out_q;

endmodule

FILE: hw/rtl/asymmetric_sine_pulse_generator.sv
// ----------------------------------------------------------------------------
// asymmetric_sine_pulse_generator
// Per-beat sample generator for an asymmetric raised-sine pulse train.
// ----------------------------------------------------------------------------
// Each accepted input beat yields one output beat carrying the next sample of
// a pulse that rises from 0 to twice the amplitude on one half-cosine and
// falls on another, plus period-end and sequence-last flags. From acceptance
// to a valid result a beat passes through the phase and counter update, the
// angle multiply, the registered sine table read and the amplitude multiply
// into the output register; that last step waits while the previous result
// is still unread. One beat is in flight at a time; a new beat is taken while
// the previous result still waits in the output register. Configuration
// writes take effect on the next beat and belong only to idle periods. There
// is no start-up sweep after reset.
// ----------------------------------------------------------------------------
module asymmetric_sine_pulse_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [asp_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [asp_pkg::SAMPLE_W-1:0]  sample_o,
  output logic                          period_end_o,
  output logic                          last_o
);
  import asp_pkg::*;

  asp_cfg_t cfg;
  asp_cmd_t cmd;

  asp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  asp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  asp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .restart_i    (restart_i),
    .sample_o     (sample_o),
    .period_end_o (period_end_o),
    .last_o       (last_o)
  );

endmodule
